// ===== sv/acc_pkg.sv =====
// ----------------------------------------------------------------------------
// acc_pkg: shared types and constants of the anchored calendar clock
// Status codes, divider widths and the month tables.
// ----------------------------------------------------------------------------
package acc_pkg;

   localparam int DIV_W = 32;
   localparam int DVS_W = 17;

   localparam logic [31:0] END_SEC = 32'd3155760000;
   localparam logic [41:0] END_MS  = 42'd3155760000000;
   localparam logic [31:0] GEN_MAX = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_ARG   = 3'd1,
      ST_RANGE = 3'd2,
      ST_LOST  = 3'd3,
      ST_UNSET = 3'd4,
      ST_GENX  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      KIND_READ = 2'd0,
      KIND_SET  = 2'd1,
      KIND_INV  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      DIV_125,
      DIV_86400,
      DIV_3600,
      DIV_60,
      DIV_7
   } div_sel_type;

   typedef struct packed {
      logic             go;
      logic [DIV_W-1:0] dividend;
      div_sel_type      sel;
   } div_req_type;

   function automatic logic [4:0] acc_days_in(input logic leap, input logic [3:0] month);
      logic [4:0] d;
      begin
         unique case (month)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
         endcase
         return d;
      end
   endfunction

   function automatic logic [8:0] acc_month_start(input logic leap, input logic [3:0] month);
      logic [8:0] d;
      begin
         unique case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            default: d = 9'd334;
         endcase
         if (leap && month > 4'd2) begin
            d = d + 9'd1;
         end
         return d;
      end
   endfunction

endpackage

// ===== sv/acc_div.sv =====
// ----------------------------------------------------------------------------
// acc_div: shared reciprocal divider for fixed divisors
// Multiply by a scaled reciprocal, multiply back, correct once; done pulses
// when quotient and remainder hold.
// ----------------------------------------------------------------------------
module acc_div import acc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  div_req_type      req,
   output logic             done,
   output logic [DIV_W-1:0] quotient,
   output logic [DVS_W-1:0] remainder
);

   localparam int R_W = DVS_W + 1;

   typedef enum logic [1:0] {
      S_IDLE, S_MUL_M, S_MUL_D, S_FIX
   } state_type;

   state_type        state_ff;
   div_sel_type      sel_ff;
   logic [DIV_W-1:0] x_ff;
   logic [DIV_W-1:0] q_ff;
   logic [R_W-1:0]   r_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [DVS_W-1:0] rem_ff;
   logic             done_ff;
   logic [31:0]      magic;
   logic [DVS_W-1:0] dvs;
   logic [31:0]      mul_a;
   logic [31:0]      mul_b;
   logic [63:0]      prod;

   always_comb begin
      unique case (sel_ff)
         DIV_125: begin
            magic = 32'd34359738;
            dvs   = 17'd125;
         end
         DIV_86400: begin
            magic = 32'd49710;
            dvs   = 17'd86400;
         end
         DIV_3600: begin
            magic = 32'd1193046;
            dvs   = 17'd3600;
         end
         DIV_60: begin
            magic = 32'd71582788;
            dvs   = 17'd60;
         end
         default: begin
            magic = 32'd613566756;
            dvs   = 17'd7;
         end
      endcase
   end

   assign mul_a = (state_ff == S_MUL_M) ? x_ff : q_ff;
   assign mul_b = (state_ff == S_MUL_M) ? magic : 32'(dvs);
   assign prod  = 64'(mul_a) * 64'(mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == S_FIX);
         unique case (state_ff)
            S_IDLE: begin
               if (req.go) begin
                  x_ff     <= req.dividend;
                  sel_ff   <= req.sel;
                  state_ff <= S_MUL_M;
               end
            end
            S_MUL_M: begin
               q_ff     <= prod[63:32];
               state_ff <= S_MUL_D;
            end
            S_MUL_D: begin
               r_ff     <= R_W'(x_ff - prod[DIV_W-1:0]);
               state_ff <= S_FIX;
            end
            default: begin
               if (r_ff >= {1'b0, dvs}) begin
                  quo_ff <= q_ff + DIV_W'(1);
                  rem_ff <= DVS_W'(r_ff - {1'b0, dvs});
               end else begin
                  quo_ff <= q_ff;
                  rem_ff <= r_ff[DVS_W-1:0];
               end
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== sv/anchored_calendar_clock.sv =====
// ----------------------------------------------------------------------------
// anchored_calendar_clock: wall clock anchored to a millisecond source
// Set, read and invalidate events on a calendar valid from 2000 to 2099.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one event per transfer: read, set from date or
//   invalidate source. Each event yields exactly one transfer on rsp_.
//   Invalidate, unknown kinds, rejected sets and reads of a clock that is not
//   ok answer from idle; a backwards source answers from S_RD_CHECK, passing
//   2100 from S_RD_RANGE. A valid set runs S_SET_DAYS then S_SET_SECS.
//   A read runs six passes of a shared reciprocal divider (milliseconds in
//   two halves, day, hour, minute, weekday), then walks years and months one
//   per cycle.
//   One event is in flight at a time; req_ready is low while an event is at
//   work or its result waits on rsp_ for rsp_ready.
//   Reset leaves the clock unset with generation zero and no result pending.
//   A stalled result holds its payload until taken.
// ----------------------------------------------------------------------------
module anchored_calendar_clock import acc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [63:0] req_source_ms,
   input  logic [15:0] req_in_year,
   input  logic [7:0]  req_in_month,
   input  logic [7:0]  req_in_day,
   input  logic [7:0]  req_in_hour,
   input  logic [7:0]  req_in_minute,
   input  logic [7:0]  req_in_second,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [11:0] rsp_out_year,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day,
   output logic [4:0]  rsp_out_hour,
   output logic [5:0]  rsp_out_minute,
   output logic [5:0]  rsp_out_second,
   output logic [9:0]  rsp_millisecond,
   output logic [2:0]  rsp_weekday,
   output logic [31:0] rsp_out_generation
);

   typedef enum logic [3:0] {
      S_IDLE, S_SET_DAYS, S_SET_SECS, S_RD_CHECK, S_RD_RANGE,
      S_DIV_MSH, S_DIV_MSL, S_DIV_DAY, S_DIV_HOUR, S_DIV_MIN, S_DIV_WEEK,
      S_YEAR, S_MONTH
   } state_type;

   state_type   state_ff;
   status_type  status_ff;
   logic [31:0] gen_ff;
   logic [63:0] anchor_src_ff;
   logic [63:0] last_src_ff;
   logic [31:0] anchor_sec_ff;

   logic [63:0] src_ff;
   logic [6:0]  yo_ff;
   logic [3:0]  mo_ff;
   logic [4:0]  d_ff;
   logic [4:0]  h_ff;
   logic [5:0]  mi_ff;
   logic [5:0]  s_ff;
   logic [63:0] elapsed_ff;
   logic [41:0] local_ff;
   logic [11:0] secs_hi_ff;
   logic [15:0] days_ff;
   logic [9:0]  msec_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  min_ff;
   logic [5:0]  sec_ff;
   logic [2:0]  wday_ff;
   logic [6:0]  yidx_ff;
   logic [3:0]  mon_ff;

   logic        rsp_valid_ff;
   status_type  rsp_status_ff;
   logic [11:0] rsp_year_ff;
   logic [3:0]  rsp_month_ff;
   logic [4:0]  rsp_day_ff;
   logic [4:0]  rsp_hour_ff;
   logic [5:0]  rsp_min_ff;
   logic [5:0]  rsp_sec_ff;
   logic [9:0]  rsp_ms_ff;
   logic [2:0]  rsp_wday_ff;
   logic [31:0] rsp_gen_ff;

   div_req_type      div_req_ff;
   div_req_type      div_req_in;
   logic             div_done;
   logic [DIV_W-1:0] div_quo;
   logic [DVS_W-1:0] div_rem;

   logic        accept;
   logic        arg_ok;
   logic        gen_bump;
   logic        range_err;
   logic [41:0] local_sum;
   logic [7:0]  yq;
   logic [15:0] set_days;
   logic [31:0] set_secs;
   logic [8:0]  yspan;
   logic [4:0]  mspan;
   logic        year_end;
   logic        month_end;
   logic        post_en;
   logic        post_full;
   status_type  post_code;

   acc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .req       (div_req_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   assign arg_ok = (req_in_year >= 16'd2000) && (req_in_year <= 16'd2099) &&
                   (req_in_month >= 8'd1) && (req_in_month <= 8'd12) &&
                   (req_in_day >= 8'd1) && (req_in_hour <= 8'd23) &&
                   (req_in_minute <= 8'd59) && (req_in_second <= 8'd59) &&
                   (req_in_day <= {3'b0, acc_days_in(req_in_year[1:0] == 2'b00,
                                                     req_in_month[3:0])});

   assign gen_bump  = (status_ff == ST_OK) && (gen_ff != GEN_MAX);
   assign range_err = (anchor_sec_ff > END_SEC) ||
                      (elapsed_ff >= {22'b0, END_MS - local_ff});
   assign local_sum = local_ff + elapsed_ff[41:0];

   assign yq       = 8'({1'b0, yo_ff} + 8'd3) >> 2;
   assign set_days = 16'(yo_ff) * 16'd365 + 16'(yq) +
                     16'(acc_month_start(yo_ff[1:0] == 2'b00, mo_ff)) + 16'(d_ff) - 16'd1;
   assign set_secs = 32'(days_ff) * 32'd86400 + 32'(h_ff) * 32'd3600 +
                     32'(mi_ff) * 32'd60 + 32'(s_ff);

   assign yspan     = (yidx_ff[1:0] == 2'b00) ? 9'd366 : 9'd365;
   assign mspan     = acc_days_in(yidx_ff[1:0] == 2'b00, mon_ff);
   assign year_end  = (yidx_ff == 7'd99) || (days_ff < 16'(yspan));
   assign month_end = (mon_ff == 4'd12) || (days_ff < 16'(mspan));

   always_comb begin
      post_en   = 1'b0;
      post_full = 1'b0;
      post_code = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               post_en = 1'b1;
               priority case (req_kind)
                  KIND_READ: begin
                     post_en   = (status_ff != ST_OK);
                     post_code = status_ff;
                  end
                  KIND_SET: begin
                     post_en = !arg_ok || (gen_ff == GEN_MAX);
                     post_code = !arg_ok ? ST_ARG : ST_GENX;
                  end
                  KIND_INV: post_code = ST_OK;
                  default:  post_code = ST_ARG;
               endcase
            end
         end
         S_SET_SECS: post_en = 1'b1;
         S_RD_CHECK: begin
            post_en   = (src_ff < last_src_ff);
            post_code = ST_LOST;
         end
         S_RD_RANGE: begin
            post_en   = range_err;
            post_code = ST_RANGE;
         end
         S_MONTH: begin
            post_en   = month_end;
            post_full = 1'b1;
         end
         default: post_en = 1'b0;
      endcase
   end

   always_comb begin
      div_req_in = '0;
      unique case (state_ff)
         S_RD_RANGE: begin
            if (!range_err) begin
               div_req_in = '{go: 1'b1, dividend: DIV_W'(local_sum[41:23]), sel: DIV_125};
            end
         end
         S_DIV_MSH: begin
            if (div_done) begin
               div_req_in = '{go: 1'b1, dividend: DIV_W'({div_rem[6:0], local_ff[22:3]}),
                              sel: DIV_125};
            end
         end
         S_DIV_MSL: begin
            if (div_done) begin
               div_req_in = '{go: 1'b1, dividend: {secs_hi_ff, div_quo[19:0]},
                              sel: DIV_86400};
            end
         end
         S_DIV_DAY: begin
            if (div_done) begin
               div_req_in = '{go: 1'b1, dividend: DIV_W'(div_rem), sel: DIV_3600};
            end
         end
         S_DIV_HOUR: begin
            if (div_done) begin
               div_req_in = '{go: 1'b1, dividend: DIV_W'(div_rem), sel: DIV_60};
            end
         end
         S_DIV_MIN: begin
            if (div_done) begin
               div_req_in = '{go: 1'b1, dividend: DIV_W'(days_ff) + DIV_W'(5), sel: DIV_7};
            end
         end
         default: div_req_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         status_ff     <= ST_UNSET;
         gen_ff        <= '0;
         anchor_src_ff <= '0;
         last_src_ff   <= '0;
         anchor_sec_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         div_req_ff    <= '0;
      end else begin
         div_req_ff <= div_req_in;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (post_en) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= post_code;
            rsp_year_ff   <= post_full ? 12'd2000 + 12'(yidx_ff) : '0;
            rsp_month_ff  <= post_full ? mon_ff : '0;
            rsp_day_ff    <= post_full ? 5'(days_ff) + 5'd1 : '0;
            rsp_hour_ff   <= post_full ? hour_ff : '0;
            rsp_min_ff    <= post_full ? min_ff : '0;
            rsp_sec_ff    <= post_full ? sec_ff : '0;
            rsp_ms_ff     <= post_full ? msec_ff : '0;
            rsp_wday_ff   <= post_full ? wday_ff : '0;
            rsp_gen_ff    <= post_full ? gen_ff : '0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  src_ff <= req_source_ms;
                  yo_ff  <= 7'(req_in_year - 16'd2000);
                  mo_ff  <= req_in_month[3:0];
                  d_ff   <= req_in_day[4:0];
                  h_ff   <= req_in_hour[4:0];
                  mi_ff  <= req_in_minute[5:0];
                  s_ff   <= req_in_second[5:0];
                  priority case (req_kind)
                     KIND_READ: begin
                        if (status_ff == ST_OK) begin
                           state_ff <= S_RD_CHECK;
                        end
                     end
                     KIND_SET: begin
                        if (arg_ok && (gen_ff != GEN_MAX)) begin
                           state_ff <= S_SET_DAYS;
                        end
                     end
                     KIND_INV: begin
                        if (gen_bump) begin
                           gen_ff <= gen_ff + 32'd1;
                        end
                        status_ff <= ST_LOST;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_SET_DAYS: begin
               days_ff  <= set_days;
               state_ff <= S_SET_SECS;
            end
            S_SET_SECS: begin
               anchor_sec_ff <= set_secs;
               anchor_src_ff <= src_ff;
               last_src_ff   <= src_ff;
               gen_ff        <= gen_ff + 32'd1;
               status_ff     <= ST_OK;
               state_ff      <= S_IDLE;
            end
            S_RD_CHECK: begin
               if (src_ff < last_src_ff) begin
                  if (gen_bump) begin
                     gen_ff <= gen_ff + 32'd1;
                  end
                  status_ff <= ST_LOST;
                  state_ff  <= S_IDLE;
               end else begin
                  elapsed_ff <= src_ff - anchor_src_ff;
                  local_ff   <= 42'(anchor_sec_ff) * 42'd1000;
                  state_ff   <= S_RD_RANGE;
               end
            end
            S_RD_RANGE: begin
               if (range_err) begin
                  if (gen_bump) begin
                     gen_ff <= gen_ff + 32'd1;
                  end
                  status_ff <= ST_RANGE;
                  state_ff  <= S_IDLE;
               end else begin
                  local_ff <= local_sum;
                  state_ff <= S_DIV_MSH;
               end
            end
            S_DIV_MSH: begin
               if (div_done) begin
                  secs_hi_ff <= div_quo[11:0];
                  state_ff   <= S_DIV_MSL;
               end
            end
            S_DIV_MSL: begin
               if (div_done) begin
                  msec_ff  <= {div_rem[6:0], local_ff[2:0]};
                  state_ff <= S_DIV_DAY;
               end
            end
            S_DIV_DAY: begin
               if (div_done) begin
                  days_ff  <= div_quo[15:0];
                  state_ff <= S_DIV_HOUR;
               end
            end
            S_DIV_HOUR: begin
               if (div_done) begin
                  hour_ff  <= div_quo[4:0];
                  state_ff <= S_DIV_MIN;
               end
            end
            S_DIV_MIN: begin
               if (div_done) begin
                  min_ff   <= div_quo[5:0];
                  sec_ff   <= div_rem[5:0];
                  state_ff <= S_DIV_WEEK;
               end
            end
            S_DIV_WEEK: begin
               if (div_done) begin
                  wday_ff  <= div_rem[2:0] + 3'd1;
                  yidx_ff  <= '0;
                  state_ff <= S_YEAR;
               end
            end
            S_YEAR: begin
               if (year_end) begin
                  mon_ff   <= 4'd1;
                  state_ff <= S_MONTH;
               end else begin
                  days_ff <= days_ff - 16'(yspan);
                  yidx_ff <= yidx_ff + 7'd1;
               end
            end
            S_MONTH: begin
               if (month_end) begin
                  last_src_ff <= src_ff;
                  state_ff    <= S_IDLE;
               end else begin
                  days_ff <= days_ff - 16'(mspan);
                  mon_ff  <= mon_ff + 4'd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_year       = rsp_year_ff;
   assign rsp_out_month      = rsp_month_ff;
   assign rsp_out_day        = rsp_day_ff;
   assign rsp_out_hour       = rsp_hour_ff;
   assign rsp_out_minute     = rsp_min_ff;
   assign rsp_out_second     = rsp_sec_ff;
   assign rsp_millisecond    = rsp_ms_ff;
   assign rsp_weekday        = rsp_wday_ff;
   assign rsp_out_generation = rsp_gen_ff;

endmodule
